/* hw/rtl/pdtq_pkg.sv */
`default_nettype none
package pdtq_pkg;

  localparam int RootCount = 3;

  // Action codes of an input word.
  localparam logic [2:0] ACT_PRIO_ENQ   = 3'd0;
  localparam logic [2:0] ACT_DELTA_ENQ  = 3'd1;
  localparam logic [2:0] ACT_DEQUEUE    = 3'd2;
  localparam logic [2:0] ACT_DETACH     = 3'd3;
  localparam logic [2:0] ACT_DETACH_DLT = 3'd4;

  // Status codes of a result word.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ID     = 3'd1;
  localparam logic [2:0] ST_QUEUED     = 3'd2;
  localparam logic [2:0] ST_NOT_QUEUED = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  // Queue word between the front and the back part.
  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  list_select;
    logic [7:0]  thread_id;
    logic [31:0] sort_key;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] thread_out;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_LINK,
    ST_DONE
  } exec_state_t;

endpackage
`default_nettype wire

/* hw/rtl/pdtq_if.sv */
`default_nettype none
interface pdtq_if #(
  parameter int Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/pdtq_front.sv */
`default_nettype none
module pdtq_front
  import pdtq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cmd_t in_cmd,
  output logic      q_valid,
  input  wire logic q_ready,
  output cmd_t      q_cmd
);

  // Two-entry queue so the front accepts while the back part works.
  cmd_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem_r[wptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr_r <= ~wptr_r;
      if (q_valid && q_ready) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pdtq_back.sv */
`default_nettype none
module pdtq_back
  import pdtq_pkg::*;
#(
  parameter int ThreadCount = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire cmd_t q_cmd,
  output logic      r_valid,
  input  wire logic r_ready,
  output rsp_t      r_rsp
);

  localparam int LinkW    = $clog2(ThreadCount + RootCount + 1);
  localparam int IdxW     = $clog2(ThreadCount);
  localparam int StepW    = $clog2(ThreadCount + 1);
  localparam logic [LinkW-1:0] LinkNull = LinkW'(ThreadCount + RootCount);

  // Node table and roots in flip-flops.
  logic [LinkW-1:0] nnext_r [ThreadCount];
  logic [LinkW-1:0] nprev_r [ThreadCount];
  logic [31:0]      nkey_r  [ThreadCount];
  logic [LinkW-1:0] rhead_r [RootCount];
  logic [LinkW-1:0] rtail_r [RootCount];

  exec_state_t state_r, state_nxt;
  cmd_t        cmd_r;
  logic [LinkW-1:0] cur_r;
  logic [31:0]      delay_r;
  logic [StepW-1:0] steps_r;
  rsp_t        rsp_r;
  rsp_t        out_r;
  logic        rv_r;

  function automatic logic is_node(input logic [LinkW-1:0] l);
    return l < LinkW'(ThreadCount);
  endfunction

  logic [IdxW-1:0]  tid;
  logic [1:0]       sel;
  logic             id_ok, sel_ok, linked_any, linked_all;
  logic [IdxW-1:0]  cur_i;
  logic [31:0]      cur_key;
  logic             walk_go;
  logic [LinkW-1:0] ins_at, ins_prev, root_code;

  assign tid        = cmd_r.thread_id[IdxW-1:0];
  assign sel        = cmd_r.list_select;
  assign id_ok      = {24'd0, cmd_r.thread_id} < 32'(ThreadCount);
  assign sel_ok     = sel < 2'd3;
  assign linked_any = (nnext_r[tid] != LinkNull) || (nprev_r[tid] != LinkNull);
  assign linked_all = (nnext_r[tid] != LinkNull) && (nprev_r[tid] != LinkNull);
  assign cur_i      = cur_r[IdxW-1:0];
  assign cur_key    = nkey_r[cur_i];
  assign root_code  = LinkW'(ThreadCount) + LinkW'(sel);
  assign walk_go    = is_node(cur_r) && (steps_r < StepW'(ThreadCount)) &&
                      ((cmd_r.action == ACT_DELTA_ENQ) ? (delay_r >= cur_key)
                                                       : (cur_key <= cmd_r.sort_key));
  assign ins_at     = is_node(cur_r) ? cur_r : root_code;
  assign ins_prev   = is_node(cur_r) ? nprev_r[cur_i] : rtail_r[sel];

  assign q_ready = (state_r == ST_IDLE);
  assign r_valid = rv_r;
  assign r_rsp   = out_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if ((cmd_r.action == ACT_PRIO_ENQ || cmd_r.action == ACT_DELTA_ENQ) &&
            id_ok && !linked_any && sel_ok) begin
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WALK:  if (!walk_go) state_nxt = ST_LINK;
      ST_LINK:  state_nxt = ST_DONE;
      ST_DONE:  if (!rv_r || r_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Output register: loaded from the finished result when the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else if (state_r == ST_DONE && (!rv_r || r_ready)) begin
      rv_r  <= 1'b1;
      out_r <= rsp_r;
    end else if (rv_r && r_ready) begin
      rv_r <= 1'b0;
    end
  end

  // Datapath: checks, list walk, relinking and the working result.
  always_ff @(posedge clk) begin
    logic [IdxW-1:0] h, si, pi;
    logic [LinkW-1:0] s, p;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < ThreadCount; i++) begin
        nnext_r[i] <= LinkNull;
        nprev_r[i] <= LinkNull;
        nkey_r[i]  <= '1;
      end
      for (int r = 0; r < RootCount; r++) begin
        rhead_r[r] <= LinkW'(ThreadCount + r);
        rtail_r[r] <= LinkW'(ThreadCount + r);
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) cmd_r <= q_cmd;
          rsp_r <= '{status: ST_OK, thread_out: 8'd0};
        end
        ST_CHECK: begin
          cur_r   <= sel_ok ? rhead_r[sel] : LinkNull;
          delay_r <= cmd_r.sort_key;
          steps_r <= '0;
          case (cmd_r.action)
            ACT_PRIO_ENQ, ACT_DELTA_ENQ: begin
              if (!id_ok) rsp_r.status <= ST_BAD_ID;
              else if (linked_any) rsp_r.status <= ST_QUEUED;
              else if (!sel_ok) rsp_r.status <= ST_EMPTY;
            end
            ACT_DEQUEUE: begin
              if (!sel_ok || !is_node(rhead_r[sel])) begin
                rsp_r.status <= ST_EMPTY;
              end else begin
                h = rhead_r[sel][IdxW-1:0];
                s = nnext_r[h];
                si = s[IdxW-1:0];
                if (sel == 2'd1 && is_node(s)) nkey_r[si] <= nkey_r[si] + nkey_r[h];
                if (is_node(s)) nprev_r[si] <= root_code;
                else rtail_r[sel] <= root_code;
                rhead_r[sel] <= s;
                nnext_r[h] <= LinkNull;
                nprev_r[h] <= LinkNull;
                rsp_r.thread_out <= 8'(h);
              end
            end
            ACT_DETACH, ACT_DETACH_DLT: begin
              if (!id_ok) rsp_r.status <= ST_BAD_ID;
              else if (!linked_all) rsp_r.status <= ST_NOT_QUEUED;
              else begin
                s = nnext_r[tid];
                p = nprev_r[tid];
                si = s[IdxW-1:0];
                pi = p[IdxW-1:0];
                if (cmd_r.action == ACT_DETACH_DLT && is_node(s)) begin
                  nkey_r[si] <= nkey_r[si] + nkey_r[tid];
                end
                if (is_node(p)) nnext_r[pi] <= s;
                else if (p < LinkNull) rhead_r[2'(p - LinkW'(ThreadCount))] <= s;
                if (is_node(s)) nprev_r[si] <= p;
                else if (s < LinkNull) rtail_r[2'(s - LinkW'(ThreadCount))] <= p;
                nnext_r[tid] <= LinkNull;
                nprev_r[tid] <= LinkNull;
                nkey_r[tid]  <= '1;
              end
            end
            default: ;
          endcase
        end
        ST_WALK: begin
          if (walk_go) begin
            if (cmd_r.action == ACT_DELTA_ENQ) delay_r <= delay_r - cur_key;
            cur_r   <= nnext_r[cur_i];
            steps_r <= steps_r + 1'b1;
          end
        end
        ST_LINK: begin
          pi = ins_prev[IdxW-1:0];
          if (is_node(ins_prev)) nnext_r[pi] <= LinkW'(tid);
          else if (ins_prev < LinkNull) begin
            rhead_r[2'(ins_prev - LinkW'(ThreadCount))] <= LinkW'(tid);
          end
          nprev_r[tid] <= ins_prev;
          nnext_r[tid] <= ins_at;
          if (is_node(ins_at)) nprev_r[cur_i] <= LinkW'(tid);
          else rtail_r[sel] <= LinkW'(tid);
          if (cmd_r.action == ACT_DELTA_ENQ) begin
            nkey_r[tid] <= delay_r;
            if (is_node(ins_at) && pi != cur_i) nkey_r[cur_i] <= cur_key - delay_r;
            else if (is_node(ins_at)) nkey_r[cur_i] <= cur_key - delay_r;
          end else begin
            nkey_r[tid] <= cmd_r.sort_key;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/priority_and_delta_thread_queues_top.sv */
`default_nettype none
// Thread queue block: ready, sleep and reap lists over a table of thread nodes.
// An enqueue walks n nodes (at most THREAD_COUNT); the walk visits one node a cycle.
// The back part takes a new word only when idle, so it finishes one word before it
// takes the next; a two-word queue decouples the input side.
// Reset (synchronous, active low) empties every list and sets all keys to ones.
module priority_and_delta_thread_queues_top
  import pdtq_pkg::*;
#(
  parameter int THREAD_COUNT = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  pdtq_if.sink     in_ch,
  pdtq_if.source   out_ch
);

  cmd_t in_cmd, q_cmd;
  rsp_t r_rsp;
  logic q_valid, q_ready;

  assign in_cmd = in_ch.data;
  assign out_ch.data = r_rsp;

  pdtq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  pdtq_back #(.ThreadCount(THREAD_COUNT)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .r_valid (out_ch.valid),
    .r_ready (out_ch.ready),
    .r_rsp   (r_rsp)
  );

endmodule
`default_nettype wire

/* sim/thread_queue_scoreboard.sv */
// Scoreboard for the thread queue block: keeps its own copy of the node
// table and list roots, predicts each result word and checks it in order.
class thread_queue_scoreboard;
  localparam int NodeCount = 16;
  localparam int LinkNull = NodeCount + pdtq_pkg::RootCount;

  int unsigned link_next[NodeCount];
  int unsigned link_prev[NodeCount];
  logic [31:0] key_of[NodeCount];
  int unsigned head_of[pdtq_pkg::RootCount];
  int unsigned tail_of[pdtq_pkg::RootCount];
  pdtq_pkg::rsp_t pending[$];
  int error_count;

  function new();
    error_count = 0;
    clear_lists();
  endfunction

  function void clear_lists();
    for (int i = 0; i < NodeCount; i++) begin
      link_next[i] = LinkNull;
      link_prev[i] = LinkNull;
      key_of[i] = '1;
    end
    for (int r = 0; r < pdtq_pkg::RootCount; r++) begin
      head_of[r] = NodeCount + r;
      tail_of[r] = NodeCount + r;
    end
    pending.delete();
  endfunction

  function bit is_node(int unsigned l);
    return l < NodeCount;
  endfunction

  function int unsigned prev_of(int unsigned l);
    if (is_node(l)) return link_prev[l];
    if (l < LinkNull) return tail_of[l - NodeCount];
    return LinkNull;
  endfunction

  function void put_next(int unsigned l, int unsigned v);
    if (is_node(l)) link_next[l] = v;
    else if (l < LinkNull) head_of[l - NodeCount] = v;
  endfunction

  function void put_prev(int unsigned l, int unsigned v);
    if (is_node(l)) link_prev[l] = v;
    else if (l < LinkNull) tail_of[l - NodeCount] = v;
  endfunction

  function void unlink(int unsigned n);
    put_next(link_prev[n], link_next[n]);
    put_prev(link_next[n], link_prev[n]);
    link_next[n] = LinkNull;
    link_prev[n] = LinkNull;
  endfunction

  function bit is_linked(int unsigned n);
    return link_next[n] != LinkNull || link_prev[n] != LinkNull;
  endfunction

  // Note one accepted input word and queue the result it should give.
  function void note_word(pdtq_pkg::cmd_t w);
    pdtq_pkg::rsp_t r;
    int unsigned cur, n, p, s, steps;
    logic [31:0] delay;
    r.status = pdtq_pkg::ST_OK;
    r.thread_out = '0;
    n = w.thread_id;
    if (w.action == pdtq_pkg::ACT_PRIO_ENQ || w.action == pdtq_pkg::ACT_DELTA_ENQ) begin
      if (n >= NodeCount) r.status = pdtq_pkg::ST_BAD_ID;
      else if (is_linked(n)) r.status = pdtq_pkg::ST_QUEUED;
      else if (w.list_select >= pdtq_pkg::RootCount) r.status = pdtq_pkg::ST_EMPTY;
      else begin
        cur = head_of[w.list_select];
        steps = 0;
        if (w.action == pdtq_pkg::ACT_DELTA_ENQ) begin
          delay = w.sort_key;
          while (is_node(cur) && steps < NodeCount && delay >= key_of[cur]) begin
            delay -= key_of[cur];
            cur = link_next[cur];
            steps++;
          end
          key_of[n] = delay;
        end else begin
          key_of[n] = w.sort_key;
          while (is_node(cur) && steps < NodeCount && key_of[cur] <= w.sort_key) begin
            cur = link_next[cur];
            steps++;
          end
        end
        if (!is_node(cur)) cur = NodeCount + w.list_select;
        // Splice the new node in front of the stop point.
        p = prev_of(cur);
        put_next(p, n);
        link_prev[n] = p;
        put_prev(cur, n);
        link_next[n] = cur;
        if (w.action == pdtq_pkg::ACT_DELTA_ENQ && is_node(cur)) key_of[cur] -= key_of[n];
      end
    end else if (w.action == pdtq_pkg::ACT_DEQUEUE) begin
      if (w.list_select >= pdtq_pkg::RootCount || !is_node(head_of[w.list_select]))
        r.status = pdtq_pkg::ST_EMPTY;
      else begin
        p = head_of[w.list_select];
        s = link_next[p];
        // The sleep list holds relative delays, so the successor absorbs the head's.
        if (w.list_select == 1 && is_node(s)) key_of[s] += key_of[p];
        unlink(p);
        r.thread_out = p;
      end
    end else if (w.action == pdtq_pkg::ACT_DETACH || w.action == pdtq_pkg::ACT_DETACH_DLT) begin
      if (n >= NodeCount) r.status = pdtq_pkg::ST_BAD_ID;
      else if (link_next[n] == LinkNull || link_prev[n] == LinkNull)
        r.status = pdtq_pkg::ST_NOT_QUEUED;
      else begin
        s = link_next[n];
        if (w.action == pdtq_pkg::ACT_DETACH_DLT && is_node(s)) key_of[s] += key_of[n];
        unlink(n);
        key_of[n] = '1;
      end
    end
    pending.push_back(r);
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // Check one result word against the oldest expectation.
  task check_word(pdtq_pkg::rsp_t got);
    pdtq_pkg::rsp_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected word status=%0d thread=%0d", got.status, got.thread_out));
    end else begin
      want = pending.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.thread_out !== want.thread_out)
        report($sformatf("thread %0d, want %0d", got.thread_out, want.thread_out));
    end
  endtask
endclass

/* sim/priority_and_delta_thread_queues_top_test.sv */
module priority_and_delta_thread_queues_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pdtq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pdtq_if #(.Width($bits(cmd_t))) in_ch ();
  pdtq_if #(.Width($bits(rsp_t))) out_ch ();

  priority_and_delta_thread_queues_top #(.THREAD_COUNT(16)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  thread_queue_scoreboard queue_model = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one, often none.
  function int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one word and hold it until it is taken.
  task send_word(cmd_t w);
    int unsigned gap;
    gap = gap_length();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    queue_model.note_word(w);
    @(negedge clk);
  endtask

  task send_fields(logic [2:0] act, logic [1:0] sel, logic [7:0] tid, logic [31:0] k);
    cmd_t w;
    w.action = act;
    w.list_select = sel;
    w.thread_id = tid;
    w.sort_key = k;
    send_word(w);
  endtask

  // Random key: small values for meaningful ordering, sometimes extremes.
  function logic [31:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return $urandom_range(0, 20);
    if (roll < 8) return $urandom();
    return roll == 8 ? 32'h0 : 32'hFFFF_FFFF;
  endfunction

  // Result side: random stalls, check at the rising edge.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ch.ready <= (gap_length() == 0);
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) queue_model.check_word(out_ch.data);
    end
  end

  initial begin
    logic [2:0] act;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty lists, bad ids, ordering, double queue, extremes.
    send_fields(ACT_DEQUEUE, 2'd0, 8'd0, 32'd0);
    send_fields(ACT_DETACH, 2'd0, 8'd3, 32'd0);
    send_fields(ACT_PRIO_ENQ, 2'd0, 8'd255, 32'd1);
    send_fields(ACT_DETACH_DLT, 2'd0, 8'd16, 32'd0);
    send_fields(ACT_PRIO_ENQ, 2'd3, 8'd1, 32'd5);
    send_fields(ACT_DEQUEUE, 2'd3, 8'd0, 32'd0);
    send_fields(ACT_PRIO_ENQ, 2'd0, 8'd1, 32'd5);
    send_fields(ACT_PRIO_ENQ, 2'd0, 8'd2, 32'd5);
    send_fields(ACT_PRIO_ENQ, 2'd0, 8'd3, 32'd0);
    send_fields(ACT_PRIO_ENQ, 2'd0, 8'd4, 32'hFFFF_FFFF);
    send_fields(ACT_PRIO_ENQ, 2'd1, 8'd2, 32'd1);
    send_fields(ACT_DELTA_ENQ, 2'd1, 8'd5, 32'd10);
    send_fields(ACT_DELTA_ENQ, 2'd1, 8'd6, 32'd4);
    send_fields(ACT_DELTA_ENQ, 2'd1, 8'd7, 32'hFFFF_FFFF);
    send_fields(ACT_DETACH_DLT, 2'd1, 8'd6, 32'd0);
    send_fields(ACT_DEQUEUE, 2'd1, 8'd0, 32'd0);
    send_fields(ACT_DETACH, 2'd0, 8'd2, 32'd0);
    send_fields(3'd5, 2'd0, 8'd0, 32'd0);
    send_fields(3'd7, 2'd3, 8'hAA, 32'h5555_5555);
    send_fields(ACT_DELTA_ENQ, 2'd2, 8'd15, 32'd0);
    send_fields(ACT_DEQUEUE, 2'd0, 8'd0, 32'd0);
    send_fields(ACT_DEQUEUE, 2'd2, 8'd0, 32'd0);

    // Random: mostly valid ids and lists so the lists fill and drain.
    repeat (750) begin
      case ($urandom_range(0, 9))
        0, 1, 2: act = ACT_PRIO_ENQ;
        3, 4: act = ACT_DELTA_ENQ;
        5, 6: act = ACT_DEQUEUE;
        7: act = ACT_DETACH;
        8: act = ACT_DETACH_DLT;
        default: act = 3'($urandom_range(0, 7));
      endcase
      send_fields(act,
                  ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                  ($urandom_range(0, 19) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 15)),
                  pick_key());
    end
    in_ch.valid <= 1'b0;

    while (queue_model.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (queue_model.error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end
endmodule
